>>> design/lru_page_replacement_top_defines.svh
// Assertion macros for the LRU page replacement block
`ifndef LRU_PAGE_REPLACEMENT_TOP_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define LRUPR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lru_page_replacement: same-cycle check failed");
`define LRUPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lru_page_replacement: next-cycle check failed");
`else
`define LRUPR_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define LRUPR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> design/lrupr_pkg.sv
package lrupr_pkg;

    localparam int MAX_FRAMES_DEF = 16;
    localparam int PAGE_BITS_DEF  = 20;
    localparam int CAP_W          = 5;
    localparam int COUNT_W        = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef struct packed {
        logic upd;
        logic append;
    } t_cell_ctrl;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == {COUNT_W{1'b1}}) ? v : v + COUNT_W'(1);
    endfunction

endpackage

>>> design/lrupr_cell.sv
module lrupr_cell #(
    parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF,
    parameter int OCC_W     = 5,
    parameter int INDEX     = 0
) (
    input  logic                   i_clk,
    input  lrupr_pkg::t_cell_ctrl  i_ctrl,
    input  logic [OCC_W-1:0]       i_occ,
    input  logic [PAGE_BITS-1:0]   i_page,
    input  logic [PAGE_BITS-1:0]   i_right,
    input  logic                   i_found,
    output logic                   o_found,
    output logic                   o_match,
    output logic [PAGE_BITS-1:0]   o_entry
);

    localparam logic [OCC_W-1:0] IDX  = OCC_W'(INDEX);
    localparam logic [OCC_W-1:0] IDX1 = OCC_W'(INDEX + 1);

    logic [PAGE_BITS-1:0] r_entry;
    logic [PAGE_BITS-1:0] n_entry;
    logic                 valid;
    logic                 nbr_valid;
    logic                 found;
    logic                 load;

    always_comb begin
        valid     = IDX < i_occ;
        nbr_valid = IDX1 < i_occ;
        o_match   = valid && (r_entry == i_page);
        found     = i_found || o_match;
        o_found   = found;
        load      = i_ctrl.append ? (IDX == i_occ) : (IDX1 == i_occ);
        n_entry   = r_entry;
        if (i_ctrl.upd) begin
            if (load) begin
                n_entry = i_page;
            end else if (found && nbr_valid) begin
                n_entry = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

>>> design/lru_page_replacement_top.sv
// LRU page tracker: one result per request, fault flag plus running totals.
// Results are registered: o_valid rises in the cycle after the input transfer.
// Throughput: 1 request per cycle while the output is not stalled; the compare
// and shift across the cell row are combinational, registered in each cell.
// Reset (synchronous, active low): clears occupancy and both totals, sets
// capacity to 16; frame contents stay undefined until written.
`include "lru_page_replacement_top_defines.svh"

module lru_page_replacement_top #(
    parameter int MAX_FRAMES = lrupr_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = lrupr_pkg::PAGE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lrupr_pkg::CAP_W-1:0]   i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [PAGE_BITS-1:0]          i_page,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_fault,
    output logic [PAGE_BITS-1:0]          o_page_out,
    output logic [lrupr_pkg::COUNT_W-1:0] o_request_total,
    output logic [lrupr_pkg::COUNT_W-1:0] o_fault_total
);

    localparam int OCC_W = $clog2(MAX_FRAMES + 1);
    localparam int CMP_W = (OCC_W > lrupr_pkg::CAP_W) ? OCC_W : lrupr_pkg::CAP_W;

    logic [lrupr_pkg::CAP_W-1:0]   r_cap;
    logic [OCC_W-1:0]              r_occ;
    logic [OCC_W-1:0]              n_occ;
    logic [lrupr_pkg::COUNT_W-1:0] r_req_cnt;
    logic [lrupr_pkg::COUNT_W-1:0] r_fault_cnt;
    logic                          r_out_valid;
    logic                          r_fault;
    logic [PAGE_BITS-1:0]          r_page;

    logic                   in_xfer;
    logic [MAX_FRAMES-1:0]  match;
    logic                   found [MAX_FRAMES];
    logic [PAGE_BITS-1:0]   entry [MAX_FRAMES+1];
    logic [CMP_W-1:0]       cap_ext;
    logic [CMP_W-1:0]       cap_eff;
    logic                   hit;
    logic                   full;
    logic                   evict;
    lrupr_pkg::t_cell_ctrl  ctrl;

    assign o_stall = r_out_valid && i_stall;
    assign in_xfer = i_valid && !o_stall;

    always_comb begin
        cap_ext    = CMP_W'(r_cap);
        cap_eff    = (cap_ext > CMP_W'(MAX_FRAMES)) ? CMP_W'(MAX_FRAMES) : cap_ext;
        hit        = |match;
        full       = CMP_W'(r_occ) >= cap_eff;
        evict      = !hit && full && (r_occ != '0);
        ctrl.upd   = in_xfer;
        ctrl.append = !hit && !full;
        n_occ      = r_occ;
        if (in_xfer && ctrl.append) begin
            n_occ = r_occ + OCC_W'(1);
        end
    end

    assign found[0]          = evict;
    assign entry[MAX_FRAMES] = '0;

    for (genvar j = 0; j < MAX_FRAMES; j++) begin : g_cell
        if (j < MAX_FRAMES - 1) begin : g_mid
            lrupr_cell #(
                .PAGE_BITS (PAGE_BITS),
                .OCC_W     (OCC_W),
                .INDEX     (j)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (ctrl),
                .i_occ   (r_occ),
                .i_page  (i_page),
                .i_right (entry[j+1]),
                .i_found (found[j]),
                .o_found (found[j+1]),
                .o_match (match[j]),
                .o_entry (entry[j])
            );
        end else begin : g_last
            lrupr_cell #(
                .PAGE_BITS (PAGE_BITS),
                .OCC_W     (OCC_W),
                .INDEX     (j)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (ctrl),
                .i_occ   (r_occ),
                .i_page  (i_page),
                .i_right (entry[j+1]),
                .i_found (found[j]),
                .o_found (),
                .o_match (match[j]),
                .o_entry (entry[j])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= lrupr_pkg::CAP_RESET;
            r_occ       <= '0;
            r_req_cnt   <= '0;
            r_fault_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (in_xfer) begin
                r_occ       <= n_occ;
                r_req_cnt   <= lrupr_pkg::sat_inc(r_req_cnt);
                if (!hit) begin
                    r_fault_cnt <= lrupr_pkg::sat_inc(r_fault_cnt);
                end
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_fault <= !hit;
            r_page  <= i_page;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_fault         = r_fault;
    assign o_page_out      = r_page;
    assign o_request_total = r_req_cnt;
    assign o_fault_total   = r_fault_cnt;

    `LRUPR_ASSERT_SAME(a_occ_bound, i_clk, i_rst_n, 1'b1, r_occ <= OCC_W'(MAX_FRAMES))
    `LRUPR_ASSERT_SAME(a_fault_le_req, i_clk, i_rst_n, 1'b1, r_fault_cnt <= r_req_cnt)
    `LRUPR_ASSERT_NEXT(a_hit_keeps_occ, i_clk, i_rst_n, in_xfer && hit, $stable(r_occ))
    `LRUPR_ASSERT_NEXT(a_xfer_result, i_clk, i_rst_n, in_xfer, o_valid && (o_request_total != '0))

endmodule

>>> tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PB      = lrupr_pkg::PAGE_BITS_DEF;
    localparam int NF      = lrupr_pkg::MAX_FRAMES_DEF;
    localparam int COUNT_W = lrupr_pkg::COUNT_W;
    localparam int CAP_W   = lrupr_pkg::CAP_W;

    typedef struct packed {
        logic               fault;
        logic [PB-1:0]      page;
        logic [COUNT_W-1:0] req;
        logic [COUNT_W-1:0] flt;
    } t_page_result;

    typedef enum bit {STEP_REQ, STEP_CFG} t_step_kind;
    typedef enum bit {CHECK_MODEL, CHECK_TYPED} t_check_kind;

    typedef struct packed {
        t_step_kind         kind;
        logic [CAP_W-1:0]   cap;
        logic [PB-1:0]      page;
        t_check_kind        chk;
        logic               fault;
        logic [COUNT_W-1:0] req;
        logic [COUNT_W-1:0] flt;
    } t_dir_step;

    typedef struct packed {
        logic [CAP_W-1:0] cap;
        int               send_idle;
        int               recv_stall;
    } t_phase;

    localparam int NUM_DIR    = 28;
    localparam int NUM_PHASES = 8;
    localparam int PHASE_LEN  = 56;

    localparam t_dir_step DIRECTED [NUM_DIR] = '{
        '{STEP_CFG, 0,  20'h00000, CHECK_MODEL, 0, 0, 0},
        '{STEP_REQ, 0,  20'h00000, CHECK_TYPED, 1, 1, 1},
        '{STEP_REQ, 0,  20'h00000, CHECK_TYPED, 1, 2, 2},
        '{STEP_REQ, 0,  20'hFFFFF, CHECK_TYPED, 1, 3, 3},
        '{STEP_CFG, 16, 20'h00000, CHECK_MODEL, 0, 0, 0},
        '{STEP_REQ, 0,  20'h00000, CHECK_TYPED, 1, 4, 4},
        '{STEP_REQ, 0,  20'h00000, CHECK_TYPED, 0, 5, 4},
        '{STEP_REQ, 0,  20'hFFFFF, CHECK_TYPED, 1, 6, 5},
        '{STEP_REQ, 0,  20'hAAAAA, CHECK_MODEL, 0, 0, 0},
        '{STEP_REQ, 0,  20'h55555, CHECK_MODEL, 0, 0, 0},
        '{STEP_REQ, 0,  20'h00001, CHECK_MODEL, 0, 0, 0},
        '{STEP_REQ, 0,  20'h80000, CHECK_MODEL, 0, 0, 0},
        '{STEP_REQ, 0,  20'h00000, CHECK_MODEL, 0, 0, 0},
        '{STEP_REQ, 0,  20'hAAAAA, CHECK_MODEL, 0, 0, 0},
        '{STEP_CFG, 2,  20'h00000, CHECK_MODEL, 0, 0, 0},
        '{STEP_REQ, 0,  20'h12345, CHECK_MODEL, 0, 0, 0},
        '{STEP_REQ, 0,  20'h55555, CHECK_MODEL, 0, 0, 0},
        '{STEP_REQ, 0,  20'hFFFFF, CHECK_MODEL, 0, 0, 0},
        '{STEP_CFG, 31, 20'h00000, CHECK_MODEL, 0, 0, 0},
        '{STEP_REQ, 0,  20'h0F0F0, CHECK_MODEL, 0, 0, 0},
        '{STEP_REQ, 0,  20'hF0F0F, CHECK_MODEL, 0, 0, 0},
        '{STEP_REQ, 0,  20'h00000, CHECK_MODEL, 0, 0, 0},
        '{STEP_CFG, 0,  20'h00000, CHECK_MODEL, 0, 0, 0},
        '{STEP_REQ, 0,  20'h00007, CHECK_MODEL, 0, 0, 0},
        '{STEP_REQ, 0,  20'h00007, CHECK_MODEL, 0, 0, 0},
        '{STEP_CFG, 1,  20'h00000, CHECK_MODEL, 0, 0, 0},
        '{STEP_REQ, 0,  20'h00003, CHECK_MODEL, 0, 0, 0},
        '{STEP_REQ, 0,  20'h00003, CHECK_MODEL, 0, 0, 0}
    };

    localparam t_phase PHASES [NUM_PHASES] = '{
        '{5'd1,  0,  0},
        '{5'd4,  64, 0},
        '{5'd16, 0,  64},
        '{5'd31, 24, 24},
        '{5'd0,  0,  0},
        '{5'd2,  64, 0},
        '{5'd8,  0,  64},
        '{5'd16, 24, 24}
    };

    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               i_cfg_we  = 1'b0;
    logic [CAP_W-1:0]   i_cfg_data = '0;
    logic               i_valid   = 1'b0;
    logic [PB-1:0]      i_page    = '0;
    logic               i_stall   = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic               o_fault;
    logic [PB-1:0]      o_page_out;
    logic [COUNT_W-1:0] o_request_total;
    logic [COUNT_W-1:0] o_fault_total;

    bit [PB-1:0]      frames [NF];
    int unsigned      resident;
    bit [COUNT_W-1:0] req_total;
    bit [COUNT_W-1:0] flt_total;
    bit [CAP_W-1:0]   capacity_reg;

    t_page_result pending_results [$];
    int           mismatch_count;
    int           send_idle_pct;
    int           recv_stall_pct;

    lru_page_replacement_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_page         (i_page),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_fault        (o_fault),
        .o_page_out     (o_page_out),
        .o_request_total(o_request_total),
        .o_fault_total  (o_fault_total)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        #(5_000_000);
        $display("== FAIL ==");
        $finish;
    end

    function automatic void drop_frame(input int unsigned pos);
        for (int unsigned k = pos; k + 1 < resident; k++) begin
            frames[k] = frames[k+1];
        end
        if (resident > 0) begin
            resident--;
        end
    endfunction

    function automatic void push_frame(input bit [PB-1:0] pg);
        if (resident < NF) begin
            frames[resident] = pg;
            resident++;
        end
    endfunction

    function automatic t_page_result lru_access(input bit [PB-1:0] pg);
        int unsigned  limit;
        int unsigned  pos;
        bit           hit;
        t_page_result r;
        limit = (capacity_reg > NF) ? NF : capacity_reg;
        hit = 1'b0;
        pos = 0;
        req_total = (req_total == '1) ? req_total : req_total + 1;
        for (int unsigned k = 0; k < resident; k++) begin
            if (!hit && frames[k] == pg) begin
                hit = 1'b1;
                pos = k;
            end
        end
        if (hit) begin
            drop_frame(pos);
            push_frame(pg);
        end else begin
            flt_total = (flt_total == '1) ? flt_total : flt_total + 1;
            if (resident >= limit) begin
                if (resident > 0) begin
                    drop_frame(0);
                    push_frame(pg);
                end
            end else begin
                push_frame(pg);
            end
        end
        r.fault = !hit;
        r.page  = pg;
        r.req   = req_total;
        r.flt   = flt_total;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [COUNT_W-1:0] got,
                                 input logic [COUNT_W-1:0] want);
        if (mismatch_count < 40) begin
            $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
        end
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_page_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("unexpected result, page", COUNT_W'(o_page_out), '0);
            end else begin
                want = pending_results.pop_front();
                if (o_fault !== want.fault) begin
                    flag_mismatch("fault", COUNT_W'(o_fault), COUNT_W'(want.fault));
                end
                if (o_page_out !== want.page) begin
                    flag_mismatch("page_out", COUNT_W'(o_page_out), COUNT_W'(want.page));
                end
                if (o_request_total !== want.req) begin
                    flag_mismatch("request_total", o_request_total, want.req);
                end
                if (o_fault_total !== want.flt) begin
                    flag_mismatch("fault_total", o_fault_total, want.flt);
                end
            end
        end
    end

    task automatic send_page(input bit [PB-1:0] pg, input t_check_kind chk,
                             input t_page_result typed);
        t_page_result predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_page  <= pg;
        do @(posedge i_clk); while (o_stall);
        predicted = lru_access(pg);
        pending_results.insert(pending_results.size(),
                               (chk == CHECK_TYPED) ? typed : predicted);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_capacity(input bit [CAP_W-1:0] value);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        capacity_reg = value;
    endtask

    initial begin
        t_page_result  typed;
        bit [PB-1:0]   pool [24];
        bit [PB-1:0]   last_page;
        bit [PB-1:0]   pg;
        int unsigned   pool_n;
        int unsigned   roll;
        mismatch_count = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        resident       = 0;
        req_total      = '0;
        flt_total      = '0;
        capacity_reg   = lrupr_pkg::CAP_RESET;
        last_page      = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < NUM_DIR; n++) begin
            if (DIRECTED[n].kind == STEP_CFG) begin
                write_capacity(DIRECTED[n].cap);
            end else begin
                typed.fault = DIRECTED[n].fault;
                typed.page  = DIRECTED[n].page;
                typed.req   = DIRECTED[n].req;
                typed.flt   = DIRECTED[n].flt;
                send_page(DIRECTED[n].page, DIRECTED[n].chk, typed);
                last_page = DIRECTED[n].page;
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            recv_stall_pct = 0;
            send_idle_pct  = 0;
            write_capacity(PHASES[p].cap);
            send_idle_pct  = PHASES[p].send_idle;
            recv_stall_pct = PHASES[p].recv_stall;
            pool_n = ((PHASES[p].cap > NF) ? NF : PHASES[p].cap) + 4;
            for (int k = 0; k < 24; k++) begin
                pool[k] = PB'($urandom_range(2**PB - 1));
            end
            for (int n = 0; n < PHASE_LEN; n++) begin
                roll = $urandom_range(99);
                if (roll < 75) begin
                    pg = pool[$urandom_range(pool_n - 1)];
                end else if (roll < 88) begin
                    pg = last_page;
                end else begin
                    pg = PB'($urandom);
                end
                send_page(pg, CHECK_MODEL, typed);
                last_page = pg;
                if (n == PHASE_LEN / 2) begin
                    drain_results();
                end
            end
        end

        drain_results();
        repeat (3) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
